FILE: rtl/core/lsfb_pkg.sv
`default_nettype none

package lsfb_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_DIGIT = 2'd2,
        OP_FRAME = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_RED   = 2'd1,
        PH_GREEN = 2'd2,
        PH_LATCH = 2'd3
    } t_phase;

    localparam int          DIGIT_SEGS = 7;
    localparam logic [7:0]  FRAME_MARK = 8'h80;
    localparam logic [2:0]  SEG_LAST   = 3'(DIGIT_SEGS - 1);

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_op  op;
        logic digit_last;
        logic out_free;
    } t_stat;

    // first LED of each seven-segment place
    function automatic logic [7:0] place_base(input logic [1:0] place);
        logic [7:0] base;
        case (place)
            2'd0:    base = 8'd65;
            2'd1:    base = 8'd58;
            2'd2:    base = 8'd50;
            default: base = 8'd43;
        endcase
        return base;
    endfunction

    // segment a in bit 0; figures above nine stay dark
    function automatic logic [6:0] seg_mask(input logic [3:0] value);
        logic [6:0] m;
        case (value)
            4'd0:    m = 7'h3F;
            4'd1:    m = 7'h06;
            4'd2:    m = 7'h5B;
            4'd3:    m = 7'h4F;
            4'd4:    m = 7'h66;
            4'd5:    m = 7'h6D;
            4'd6:    m = 7'h7D;
            4'd7:    m = 7'h07;
            4'd8:    m = 7'h7F;
            4'd9:    m = 7'h6F;
            default: m = 7'h00;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/led_strip_frame_buffer_top.sv
`default_nettype none

// channel   dir  handshake                   payload
// s_axis    in   tvalid/tready               tuser opcode, tdata item fields
// m_axis    out  tvalid/tready               tuser status, tdata, tlast
// cfg       in   i_cfg_valid/o_cfg_ready     segment_color
//
// Write, read and frame tick each go through capture, one buffer
// access on the RAM, then the load into the output register.
// Set digit makes seven segment writes through the RAM write port.
// Reset is synchronous; it clears the per-LED valid bits, so the buffer
// reads as zero at once with no clearing pass.
// A result waiting in the output register holds the next item at its end.

module led_strip_frame_buffer_top
    import lsfb_pkg::*;
#(
    parameter int LED_COUNT = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [7:0] start_offset, [15:8] run_length, [23:16] position,
    // [31:24] byte_data, [33:32] digit_place, [37:34] digit_value
    input  wire logic [39:0] i_s_axis_tdata,
    // [1:0] opcode
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [7:0] read_data, [15:8] frame_byte
    output logic [15:0]      o_m_axis_tdata,
    // [0] status
    output logic             o_m_axis_tuser,
    output logic             o_m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    lsfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lsfb_dp #(
        .LED_COUNT (LED_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (i_s_axis_tuser),
        .i_start_offset (i_s_axis_tdata[7:0]),
        .i_run_length   (i_s_axis_tdata[15:8]),
        .i_position     (i_s_axis_tdata[23:16]),
        .i_byte_data    (i_s_axis_tdata[31:24]),
        .i_digit_place  (i_s_axis_tdata[33:32]),
        .i_digit_value  (i_s_axis_tdata[37:34]),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_status       (o_m_axis_tuser),
        .o_read_data    (o_m_axis_tdata[7:0]),
        .o_frame_byte   (o_m_axis_tdata[15:8]),
        .o_frame_last   (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/core/lsfb_ram.sv
`default_nettype none

module lsfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/lsfb_ctrl.sv
`default_nettype none

module lsfb_ctrl
    import lsfb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PUT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    // a digit stays here for one write per segment
                    if (i_stat.op != OP_DIGIT || i_stat.digit_last) r_state <= S_PUT;
                end
                S_PUT: begin
                    if (i_stat.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.load    = (r_state == S_PUT) && i_stat.out_free;
    end

endmodule

`default_nettype wire

FILE: rtl/core/lsfb_dp.sv
`default_nettype none

module lsfb_dp
    import lsfb_pkg::*;
#(
    parameter int LED_COUNT = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_start_offset,
    input  wire logic [7:0]  i_run_length,
    input  wire logic [7:0]  i_position,
    input  wire logic [7:0]  i_byte_data,
    input  wire logic [1:0]  i_digit_place,
    input  wire logic [3:0]  i_digit_value,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_status,
    output logic [7:0]       o_read_data,
    output logic [7:0]       o_frame_byte,
    output logic             o_frame_last
);

    localparam int         AW   = $clog2(LED_COUNT);
    localparam logic [8:0] LC   = 9'(LED_COUNT);
    localparam logic [AW-1:0] LAST_LED = AW'(LED_COUNT - 1);

    // captured item
    t_op        r_op;
    logic [7:0] r_start, r_len, r_pos, r_data;
    logic [1:0] r_place;
    logic [3:0] r_value;
    logic [2:0] r_k;

    logic [7:0] r_color;

    // frame serializer position
    logic [AW-1:0] r_send_led;
    t_phase        r_send_phase;

    // execution results held for the output load
    logic   r_reject, r_hit, r_vld, r_flast;
    t_phase r_fphase;

    // per-entry valid bits; an unwritten LED reads as zero
    logic [LED_COUNT-1:0] r_valid;

    logic       r_out_valid, r_out_status, r_out_last;
    logic [7:0] r_out_rd, r_out_fb;

    logic [8:0]    run_end, idx, daddr;
    logic          reject, in_run, d_ok, dbit;
    logic [6:0]    seg;
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata, pix, fb;
    logic          led_wrap;

    always_comb begin
        run_end = {1'b0, r_start} + {1'b0, r_len};
        reject  = ({1'b0, r_start} >= LC) || (run_end > LC);
        idx     = {1'b0, r_start} + {1'b0, r_pos};
        in_run  = !reject && (r_pos < r_len) && (idx < LC);

        daddr = {1'b0, place_base(r_place)} + {6'd0, r_k};
        d_ok  = (daddr < LC);
        seg   = seg_mask(r_value);
        dbit  = seg[r_k];

        we    = i_cmd.exec && (((r_op == OP_WRITE) && in_run) || ((r_op == OP_DIGIT) && d_ok));
        waddr = (r_op == OP_DIGIT) ? daddr[AW-1:0] : idx[AW-1:0];
        wdata = (r_op == OP_DIGIT) ? (dbit ? r_color : 8'd0) : r_data;
        re    = i_cmd.exec && ((r_op == OP_READ) || (r_op == OP_FRAME));
        raddr = (r_op == OP_FRAME) ? r_send_led : idx[AW-1:0];

        led_wrap = (r_send_led == LAST_LED);
    end

    lsfb_ram #(
        .WIDTH (8),
        .DEPTH (LED_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_opcode);
            r_start <= i_start_offset;
            r_len   <= i_run_length;
            r_pos   <= i_position;
            r_data  <= i_byte_data;
            r_place <= i_digit_place;
            r_value <= i_digit_value;
        end
        if (i_cmd.exec) begin
            r_reject <= reject;
            r_hit    <= in_run;
            r_vld    <= r_valid[raddr];
            r_fphase <= r_send_phase;
            r_flast  <= (r_send_phase == PH_LATCH) && led_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k          <= 3'd0;
            r_color      <= 8'd0;
            r_send_led   <= '0;
            r_send_phase <= PH_BLUE;
            r_valid      <= '0;
        end else begin
            if (i_cfg_we) r_color <= i_cfg_data;
            if (i_cmd.capture) begin
                r_k <= 3'd0;
            end else if (i_cmd.exec && r_op == OP_DIGIT) begin
                r_k <= r_k + 3'd1;
            end
            if (we) r_valid[waddr] <= 1'b1;
            if (i_cmd.exec && r_op == OP_FRAME) begin
                case (r_send_phase)
                    PH_BLUE: r_send_phase <= PH_RED;
                    PH_RED:  r_send_phase <= PH_GREEN;
                    PH_GREEN: begin
                        if (led_wrap) begin
                            r_send_led   <= '0;
                            r_send_phase <= PH_LATCH;
                        end else begin
                            r_send_led   <= r_send_led + AW'(1);
                            r_send_phase <= PH_BLUE;
                        end
                    end
                    PH_LATCH: begin
                        if (led_wrap) begin
                            r_send_led   <= '0;
                            r_send_phase <= PH_BLUE;
                        end else begin
                            r_send_led   <= r_send_led + AW'(1);
                        end
                    end
                    default: r_send_phase <= PH_BLUE;
                endcase
            end
        end
    end

    // strip byte: 0x80 marker, color bits in 6..4 (blue: two bits in 6..5); latch byte is zero
    always_comb begin
        pix = r_vld ? rdata : 8'd0;
        case (r_fphase)
            PH_BLUE:  fb = FRAME_MARK | {1'b0, pix[1:0], 5'd0};
            PH_RED:   fb = FRAME_MARK | {1'b0, pix[7:5], 4'd0};
            PH_GREEN: fb = FRAME_MARK | {1'b0, pix[4:2], 4'd0};
            default:  fb = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_status <= ((r_op == OP_WRITE) || (r_op == OP_READ)) && r_reject;
            r_out_rd     <= ((r_op == OP_READ) && r_hit) ? pix : 8'd0;
            r_out_fb     <= (r_op == OP_FRAME) ? fb : 8'd0;
            r_out_last   <= (r_op == OP_FRAME) && r_flast;
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.digit_last = (r_k == SEG_LAST);
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_read_data  = r_out_rd;
    assign o_frame_byte = r_out_fb;
    assign o_frame_last = r_out_last;

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lsfb_pkg::*;

    localparam int LEDS            = 128;
    localparam int WATCHDOG_CYCLES = 400000;
    localparam int SETTLE_CYCLES   = 12;   // longest item is a digit

    localparam logic [6:0] DIGIT_SHAPES [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };
    localparam int PLACE_FIRST_LED [4] = '{65, 58, 50, 43};

    typedef struct {
        t_op        op;
        logic [7:0] start_led;
        logic [7:0] run_len;
        logic [7:0] run_pos;
        logic [7:0] color;
        logic [1:0] place;
        logic [3:0] figure;
    } t_strip_item;

    typedef struct {
        logic       status;
        logic [7:0] read_byte;
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_strip_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        src_valid;
    logic [39:0] src_data;
    logic [1:0]  src_user;
    logic        sink_ready;
    logic        cfg_valid;
    logic [7:0]  cfg_data;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [15:0] o_m_axis_tdata;
    wire         o_m_axis_tuser;
    wire         o_m_axis_tlast;
    wire         o_cfg_ready;

    // shadow of the strip buffer and frame sender
    logic [7:0]    strip_pixels [LEDS];
    logic [7:0]    lit_color;
    int            frame_led;
    t_phase        frame_phase;
    t_strip_result pending_results [$];

    bit gaps_on;
    int items_sent;
    int results_seen;
    int frames_seen;
    int digits_drawn;
    int mismatches;
    int cycle_count;
    int sink_hold;

    led_strip_frame_buffer_top #(
        .LED_COUNT(LEDS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (src_data),
        .i_s_axis_tuser  (src_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (sink_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= WATCHDOG_CYCLES);
        $display("timeout after %0d cycles, %0d results still pending",
                 cycle_count, pending_results.size());
        $display("testbench NOT OK");
        $finish;
    end

    // Works out the result of one accepted item and advances the shadow state.
    function automatic t_strip_result predict_item(input t_strip_item it);
        t_strip_result r;
        int            led;
        logic [7:0]    px;
        logic [6:0]    shape;
        r = '{1'b0, 8'd0, 8'd0, 1'b0};
        case (it.op)
            OP_WRITE, OP_READ: begin
                if (int'(it.start_led) > LEDS - 1 ||
                    int'(it.start_led) + int'(it.run_len) > LEDS) begin
                    r.status = 1'b1;
                end else if (it.run_pos < it.run_len) begin
                    led = int'(it.start_led) + int'(it.run_pos);
                    if (it.op == OP_WRITE) begin
                        strip_pixels[led] = it.color;
                    end else begin
                        r.read_byte = strip_pixels[led];
                    end
                end
            end
            OP_DIGIT: begin
                shape = (it.figure < 4'd10) ? DIGIT_SHAPES[it.figure] : 7'h00;
                for (int k = 0; k < 7; k++) begin
                    strip_pixels[PLACE_FIRST_LED[it.place] + k] = shape[k] ? lit_color : 8'h00;
                end
            end
            default: begin
                px = strip_pixels[frame_led];
                case (frame_phase)
                    PH_BLUE:  r.frame_byte = FRAME_MARK | {1'b0, px[1:0], 5'b0};
                    PH_RED:   r.frame_byte = FRAME_MARK | {1'b0, px[7:5], 4'b0};
                    PH_GREEN: r.frame_byte = FRAME_MARK | {1'b0, px[4:2], 4'b0};
                    default:  r.frame_byte = 8'h00;
                endcase
                if (frame_phase == PH_GREEN || frame_phase == PH_LATCH) begin
                    if (frame_led == LEDS - 1) begin
                        r.frame_last = (frame_phase == PH_LATCH);
                        frame_phase  = (frame_phase == PH_GREEN) ? PH_LATCH : PH_BLUE;
                        frame_led    = 0;
                    end else begin
                        frame_led++;
                        if (frame_phase == PH_GREEN) begin
                            frame_phase = PH_BLUE;
                        end
                    end
                end else begin
                    frame_phase = t_phase'(frame_phase + 2'd1);
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // result sink: random stall after each result when gaps are on, compare on acceptance
    initial begin
        t_strip_result want;
        sink_ready = 1'b0;
        sink_hold  = 0;
        forever begin
            @(negedge i_clk);
            sink_ready = (sink_hold == 0);
            if (sink_hold > 0) begin
                sink_hold--;
            end
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && sink_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending, tdata %h",
                                              o_m_axis_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_axis_tuser !== want.status) begin
                        report_mismatch($sformatf("result %0d status %b, want %b",
                                                  results_seen, o_m_axis_tuser, want.status));
                    end
                    if (o_m_axis_tdata[7:0] !== want.read_byte) begin
                        report_mismatch($sformatf("result %0d read byte %h, want %h",
                                                  results_seen, o_m_axis_tdata[7:0],
                                                  want.read_byte));
                    end
                    if (o_m_axis_tdata[15:8] !== want.frame_byte) begin
                        report_mismatch($sformatf("result %0d frame byte %h, want %h",
                                                  results_seen, o_m_axis_tdata[15:8],
                                                  want.frame_byte));
                    end
                    if (o_m_axis_tlast !== want.frame_last) begin
                        report_mismatch($sformatf("result %0d frame last %b, want %b",
                                                  results_seen, o_m_axis_tlast,
                                                  want.frame_last));
                    end
                    if (want.frame_last) begin
                        frames_seen++;
                    end
                end
                sink_hold = gaps_on ? $urandom_range(0, 15) : 0;
            end
        end
    end

    // Leaves tvalid high after acceptance so back-to-back items need no drop.
    task automatic send_item(input t_strip_item it);
        int gap;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            src_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        src_valid = 1'b1;
        src_user  = it.op;
        src_data  = {2'b00, it.figure, it.place, it.color, it.run_pos, it.run_len,
                     it.start_led};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(predict_item(it));
        items_sent++;
        if (it.op == OP_DIGIT) begin
            digits_drawn++;
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        src_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [7:0] c);
        wait_idle();
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data  = c;
        do @(posedge i_clk); while (!o_cfg_ready);
        lit_color = c;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic t_strip_item run_item(input t_op op, input logic [7:0] start_led,
                                             input logic [7:0] run_len,
                                             input logic [7:0] run_pos,
                                             input logic [7:0] color);
        t_strip_item it;
        it = '{op, start_led, run_len, run_pos, color, 2'd0, 4'd0};
        return it;
    endfunction

    function automatic t_strip_item digit_item(input logic [1:0] place,
                                               input logic [3:0] figure);
        t_strip_item it;
        it = '{OP_DIGIT, 8'd0, 8'd0, 8'd0, 8'd0, place, figure};
        return it;
    endfunction

    function automatic t_strip_item noise_item();
        t_strip_item it;
        it.op        = t_op'($urandom_range(0, 3));
        it.start_led = 8'($urandom);
        it.run_len   = 8'($urandom);
        it.run_pos   = 8'($urandom);
        it.color     = 8'($urandom);
        it.place     = 2'($urandom);
        it.figure    = 4'($urandom);
        return it;
    endfunction

    task automatic test_reset_state();
        send_item(run_item(OP_READ, 8'd0, 8'd128, 8'd0, 8'h00));
        send_item(run_item(OP_READ, 8'd0, 8'd128, 8'd127, 8'h00));
        send_item(run_item(OP_READ, 8'd64, 8'd1, 8'd0, 8'h00));
        // reset color is zero, so this digit stays dark
        send_item(digit_item(2'd0, 4'd8));
        send_item(run_item(OP_READ, 8'd65, 8'd7, 8'd0, 8'h00));
    endtask

    task automatic test_run_bounds();
        send_item(run_item(OP_WRITE, 8'd0, 8'd1, 8'd0, 8'hFF));
        send_item(run_item(OP_WRITE, 8'd127, 8'd1, 8'd0, 8'hA5));
        send_item(run_item(OP_WRITE, 8'd0, 8'd128, 8'd127, 8'h5A));
        send_item(run_item(OP_READ, 8'd0, 8'd1, 8'd0, 8'h00));
        send_item(run_item(OP_READ, 8'd127, 8'd1, 8'd0, 8'h00));
        // start past the end, and a run that spills over it
        send_item(run_item(OP_WRITE, 8'd128, 8'd0, 8'd0, 8'h11));
        send_item(run_item(OP_WRITE, 8'd1, 8'd128, 8'd0, 8'h22));
        send_item(run_item(OP_READ, 8'd255, 8'd255, 8'd255, 8'hFF));
        send_item(run_item(OP_READ, 8'd1, 8'd1, 8'd0, 8'h00));
        // empty run, and a position beyond the run
        send_item(run_item(OP_WRITE, 8'd5, 8'd0, 8'd0, 8'h33));
        send_item(run_item(OP_WRITE, 8'd10, 8'd3, 8'd3, 8'h44));
        send_item(run_item(OP_READ, 8'd10, 8'd3, 8'd200, 8'h00));
        send_item(run_item(OP_READ, 8'd13, 8'd1, 8'd0, 8'h00));
        send_item(run_item(OP_READ, 8'd5, 8'd1, 8'd0, 8'h00));
    endtask

    task automatic test_digit_places();
        write_color(8'hFF);
        send_item(digit_item(2'd0, 4'd8));
        send_item(digit_item(2'd1, 4'd1));
        send_item(digit_item(2'd2, 4'd10));
        send_item(digit_item(2'd3, 4'd15));
        for (int led = 43; led < 72; led += 4) begin
            send_item(run_item(OP_READ, 8'(led), 8'd4, 8'd0, 8'h00));
        end
        write_color(8'h96);
        for (int fig = 0; fig < 10; fig++) begin
            send_item(digit_item(2'(fig), 4'(fig)));
        end
        send_item(run_item(OP_READ, 8'd43, 8'd29, 8'd6, 8'h00));
    endtask

    // Mostly well-formed runs with random content, some digits and frame ticks,
    // the rest random fields.
    task automatic random_phase(input int count);
        t_strip_item it;
        int          start_led;
        int          run_len;
        int          burst;
        int          pick;
        int          sent;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                start_led = $urandom_range(0, LEDS - 1);
                run_len   = $urandom_range(0, LEDS - start_led);
                if ($urandom_range(0, 1)) begin
                    run_len = (run_len < 8) ? run_len : $urandom_range(0, 8);
                end
                burst = (run_len == 0) ? 1 : $urandom_range(1, (run_len < 4) ? run_len : 4);
                for (int b = 0; b < burst; b++) begin
                    it = run_item($urandom_range(0, 2) ? OP_WRITE : OP_READ, 8'(start_led),
                                  8'(run_len), 8'(run_len == 0 ? 0 : $urandom_range(0, run_len - 1)),
                                  8'($urandom));
                    send_item(it);
                    sent++;
                end
            end else if (pick < 75) begin
                send_item(digit_item(2'($urandom), 4'($urandom_range(0, 15))));
                sent++;
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(run_item(OP_FRAME, 8'd0, 8'd0, 8'd0, 8'h00));
                    sent++;
                end
            end else begin
                send_item(noise_item());
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        write_color(8'h00);
        gaps_on = 1'b1;
        random_phase(20);
        write_color(8'($urandom));
        gaps_on = 1'b0;
        random_phase(20);
        write_color(8'hFF);
        gaps_on = 1'b1;
        random_phase(20);
        write_color(8'($urandom));
        random_phase(20);
    endtask

    // Runs the sender on to the end of the current frame, so at least one latch end.
    task automatic test_frame_stream();
        int ticks;
        for (int led = 0; led < LEDS; led += 8) begin
            send_item(run_item(OP_WRITE, 8'(led), 8'd1, 8'd0, 8'($urandom)));
        end
        ticks   = 0;
        gaps_on = 1'b0;
        do begin
            if (ticks == LEDS) begin
                gaps_on = 1'b1;
            end
            send_item(run_item(OP_FRAME, 8'd0, 8'd0, 8'd0, 8'h00));
            ticks++;
        end while (!(frame_phase == PH_BLUE && frame_led == 0) && ticks < 4 * LEDS);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        src_valid   = 1'b0;
        src_data    = '0;
        src_user    = OP_WRITE;
        cfg_valid   = 1'b0;
        cfg_data    = 8'h00;
        gaps_on     = 1'b1;
        lit_color   = 8'h00;
        frame_led   = 0;
        frame_phase = PH_BLUE;
        foreach (strip_pixels[i]) begin
            strip_pixels[i] = 8'h00;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_run_bounds();
        test_digit_places();
        test_random_traffic();
        test_frame_stream();

        wait_idle();
        $display("covered %0d items, %0d results checked: runs in and out of range,",
                 items_sent, results_seen);
        $display("%0d digits drawn, %0d full strip frames, color writes at both extremes",
                 digits_drawn, frames_seen);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
